// ----- hdl/esu_pkg.sv -----
// Shared constants, types and helper functions of the embedding SGD update unit.
// Holds the sigmoid table built at elaboration; no dependencies.
`default_nettype none

package esu_pkg;

   // Sizes of the embedding stores and the sigmoid table.
   localparam int MAX_VERTICES    = 4096;
   localparam int MAX_DIM         = 128;
   localparam int SIGMOID_ENTRIES = 1000;

   localparam int VTX_W     = $clog2(MAX_VERTICES);
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int LEN_W     = $clog2(MAX_DIM + 1);
   localparam int ADDR_W    = VTX_W + DIM_W;
   localparam int MEM_DEPTH = MAX_VERTICES * MAX_DIM;

   // Field widths fixed by the interface.
   localparam int ELEM_W   = 16;
   localparam int GRAD_W   = 17;
   localparam int ACC_W    = 24;
   localparam int VLEN_W   = 8;
   localparam int RATE_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W     = 3;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Dot product accumulator: products up to 2^30 summed over MAX_DIM elements.
   localparam int DOT_W = 32 + DIM_W;

   // Sigmoid lookup: the clamp window is +-6 in Q.24, twelve units wide.
   localparam int SIG_BOUND      = 6 << 24;
   localparam int SPAN_W         = 28;
   localparam int SPAN_SHIFT     = 26;
   localparam int SCALED_W       = SPAN_W + $clog2(SIGMOID_ENTRIES + 1);
   localparam int QUOT_W         = SCALED_W - SPAN_SHIFT;
   localparam int RECIP3         = 21846;
   localparam int RECIP_SHIFT    = 16;
   localparam int RECIP_W        = 15;
   localparam int KQ_W           = $clog2(SIGMOID_ENTRIES + 1);
   localparam int SIG_IDX_W      = $clog2(SIGMOID_ENTRIES);
   localparam int SIG_W          = 17;
   localparam int ONE_Q16        = 65536;

   localparam logic signed [DOT_W-1:0] SIG_BOUND_DOT = DOT_W'(SIG_BOUND);

   // Operation codes of a transaction.
   localparam logic [OP_W-1:0] OP_TRAIN  = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_VTX = 3'd1;
   localparam logic [OP_W-1:0] OP_WR_CTX = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_VTX = 3'd3;
   localparam logic [OP_W-1:0] OP_RD_CTX = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_MODE    = 2'd2;

   // Request to one embedding store: one write and one read per cycle.
   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic signed [ELEM_W-1:0] wdata;
      logic [ADDR_W-1:0]        raddr;
   } mem_req_type;

   // Request to the error accumulator.
   typedef struct packed {
      logic                    clear_all;
      logic                    we;
      logic [DIM_W-1:0]        waddr;
      logic signed [ACC_W-1:0] wdata;
      logic [DIM_W-1:0]        raddr;
   } acc_req_type;

   typedef logic [15:0] sig_rom_type [SIGMOID_ENTRIES];

   // Round to nearest with ties away from zero, then shift right.
   function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                      input int sh);
      logic signed [47:0] mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (48'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   // Saturate to a signed field of the given width.
   function automatic logic signed [47:0] sat_bits(input logic signed [47:0] v,
                                                   input int bits);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< (bits - 1)) - 48'sd1;
      lo = -(48'sd1 <<< (bits - 1));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // Restoring shift-subtract divide, used only while building the table.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Logistic of -6 + 12*i/SIGMOID_ENTRIES in Q0.16, from a Q2.30 series of exp.
   function automatic logic [15:0] logistic_entry(input int i);
      longint      num12;
      logic        neg;
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] term;
      longint      sum;
      logic [63:0] t;
      logic [63:0] den;
      logic [63:0] nume;
      logic [63:0] res;
      num12 = 12 * longint'(i) - 6 * longint'(SIGMOID_ENTRIES);
      neg   = (num12 < 0);
      a     = neg ? 64'(-num12) : 64'(num12);
      r     = udiv64(a << 30, 64'(64 * SIGMOID_ENTRIES));
      term  = 64'd1 << 30;
      sum   = longint'(1) << 30;
      for (int k = 1; k <= 6; k++) begin
         term = udiv64((term * r) >> 30, 64'(k));
         sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      t = 64'(sum);
      for (int k = 0; k < 6; k++) begin
         t = (t * t + (64'd1 << 29)) >> 30;
      end
      den  = (64'd1 << 30) + t;
      nume = neg ? t : (64'd1 << 30);
      res  = udiv64((nume << 16) + (den >> 1), den);
      return res[15:0];
   endfunction

   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
         rom[i] = logistic_entry(i);
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

`default_nettype wire

// ----- hdl/esu_mem.sv -----
// Vertex and context embedding stores, one write and one registered read each.
// Depends on esu_pkg for sizes and the store request type.
`default_nettype none

module esu_mem (
   input  wire logic                                  clock,
   input  wire esu_pkg::mem_req_type                  vtx_req,
   input  wire esu_pkg::mem_req_type                  ctx_req,
   output logic signed [esu_pkg::ELEM_W-1:0]          vtx_rdata_ff,
   output logic signed [esu_pkg::ELEM_W-1:0]          ctx_rdata_ff
);

   logic signed [esu_pkg::ELEM_W-1:0] vertex_mem_ff  [esu_pkg::MEM_DEPTH];
   logic signed [esu_pkg::ELEM_W-1:0] context_mem_ff [esu_pkg::MEM_DEPTH];

   // Vertex store port.
   always_ff @(posedge clock) begin
      if (vtx_req.we) begin
         vertex_mem_ff[vtx_req.waddr] <= vtx_req.wdata;
      end
      vtx_rdata_ff <= vertex_mem_ff[vtx_req.raddr];
   end

   // Context store port.
   always_ff @(posedge clock) begin
      if (ctx_req.we) begin
         context_mem_ff[ctx_req.waddr] <= ctx_req.wdata;
      end
      ctx_rdata_ff <= context_mem_ff[ctx_req.raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/esu_acc.sv -----
// Error accumulator store with per-entry valid bits; invalid entries read as zero.
// Depends on esu_pkg for sizes and the accumulator request type.
`default_nettype none

module esu_acc (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire esu_pkg::acc_req_type          req,
   output logic signed [esu_pkg::ACC_W-1:0]   rdata
);

   logic signed [esu_pkg::ACC_W-1:0] acc_mem_ff [esu_pkg::MAX_DIM];
   logic [esu_pkg::MAX_DIM-1:0]      valid_ff;
   logic signed [esu_pkg::ACC_W-1:0] acc_rdata_ff;
   logic                             rvalid_ff;

   // Storage and registered read.
   always_ff @(posedge clock) begin
      if (req.we) begin
         acc_mem_ff[req.waddr] <= req.wdata;
      end
      acc_rdata_ff <= acc_mem_ff[req.raddr];
   end

   // A cleared entry must read as zero until it is written again.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[req.raddr];
         if (req.clear_all) begin
            valid_ff <= '0;
         end else if (req.we) begin
            valid_ff[req.waddr] <= 1'b1;
         end
      end
   end

   assign rdata = rvalid_ff ? acc_rdata_ff : '0;

endmodule

`default_nettype wire

// ----- hdl/esu_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on esu_pkg for operand widths.
`default_nettype none

module esu_mul (
   input  wire logic                                clock,
   input  wire logic signed [esu_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic signed [esu_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [esu_pkg::PROD_W-1:0]        product_ff
);

   // One product per cycle, available the cycle after the operands.
   always_ff @(posedge clock) begin
      product_ff <= esu_pkg::PROD_W'(mul_a) * esu_pkg::PROD_W'(mul_b);
   end

endmodule

`default_nettype wire

// ----- hdl/embedding_sgd_update_unit.sv -----
// Top level of the embedding SGD update unit: sequencer, configuration registers.
// Depends on esu_pkg, esu_mem, esu_acc and esu_mul.
`default_nettype none

// One transaction is taken when start is high and busy is low; busy is high while
// a read or train transaction is in progress and falls as its single result is
// shown with rsp_valid for one cycle, which the receiver must take then. Writes
// and unknown operations never raise busy and answer the cycle after start;
// reads answer from the S_READ state, after the registered store read. A train
// transaction runs the dot product over the L elements in use, then the sigmoid
// and gradient, then the update pass and, when last_of_sample is set, a pass
// that writes the source vector; then it answers. Each element runs in phases
// over the single shared multiplier and the one read port of each store.
// The embedding stores hold unknown data until written; there is no clearing
// pass, and the error accumulator is cleared at once by its valid bits.
module embedding_sgd_update_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [esu_pkg::OP_W-1:0]             req_operation,
   input  wire logic [11:0]                          req_source_vertex,
   input  wire logic [11:0]                          req_target_vertex,
   input  wire logic                                 req_label,
   input  wire logic                                 req_last_of_sample,
   input  wire logic [6:0]                           req_element_index,
   input  wire logic signed [esu_pkg::ELEM_W-1:0]    req_element_value,
   output logic                                      rsp_valid,
   output logic signed [esu_pkg::ELEM_W-1:0]         rsp_read_data,
   output logic signed [esu_pkg::GRAD_W-1:0]         rsp_gradient_scale,
   input  wire logic                                 csr_write_enable,
   input  wire logic [esu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [esu_pkg::CSR_W-1:0]            csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DOT,
      S_SIG_RANGE,
      S_SIG_DIV,
      S_SIG_ROM,
      S_GRAD_MUL,
      S_GRAD_RND,
      S_UPD,
      S_LAST
   } state_type;

   localparam int DIM_W = esu_pkg::DIM_W;
   localparam int VTX_W = esu_pkg::VTX_W;
   localparam int LEN_W = esu_pkg::LEN_W;

   // Configuration registers.
   logic [esu_pkg::VLEN_W-1:0] vector_length_ff;
   logic [esu_pkg::RATE_W-1:0] learning_rate_ff;
   logic                       order_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= esu_pkg::VLEN_W'(100);
         learning_rate_ff <= esu_pkg::RATE_W'(1638);
         order_mode_ff    <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            esu_pkg::CSR_VECTOR_LENGTH: begin
               vector_length_ff <= csr_write_data[esu_pkg::VLEN_W-1:0];
            end
            esu_pkg::CSR_LEARNING_RATE: begin
               learning_rate_ff <= csr_write_data[esu_pkg::RATE_W-1:0];
            end
            esu_pkg::CSR_ORDER_MODE: begin
               order_mode_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and per-transaction registers.
   state_type                          state_ff;
   logic [2:0]                         phase_ff;
   logic [LEN_W-1:0]                   elem_ff;
   logic [LEN_W-1:0]                   len_ff;
   logic [VTX_W-1:0]                   src_ff;
   logic [VTX_W-1:0]                   tgt_ff;
   logic                               label_ff;
   logic                               last_ff;
   logic signed [esu_pkg::ELEM_W-1:0]  s_ff;
   logic signed [esu_pkg::ELEM_W-1:0]  t_ff;
   logic signed [esu_pkg::DOT_W-1:0]   dot_ff;
   logic [esu_pkg::SCALED_W-1:0]       scaled_ff;
   logic [esu_pkg::KQ_W-1:0]           kq_ff;
   logic [esu_pkg::SIG_W-1:0]          sig_ff;
   logic signed [esu_pkg::GRAD_W-1:0]  g_ff;
   logic                               rsp_valid_ff;
   logic signed [esu_pkg::ELEM_W-1:0]  rsp_read_data_ff;
   logic signed [esu_pkg::GRAD_W-1:0]  rsp_grad_ff;

   // Submodule connections.
   esu_pkg::mem_req_type               vtx_req;
   esu_pkg::mem_req_type               ctx_req;
   esu_pkg::acc_req_type               acc_req;
   logic signed [esu_pkg::ELEM_W-1:0]  vtx_rdata;
   logic signed [esu_pkg::ELEM_W-1:0]  ctx_rdata;
   logic signed [esu_pkg::ACC_W-1:0]   acc_rdata;
   logic signed [esu_pkg::MUL_A_W-1:0] mul_a;
   logic signed [esu_pkg::MUL_B_W-1:0] mul_b;
   logic signed [esu_pkg::PROD_W-1:0]  product;

   esu_mem u_mem (
      .clock        (clock),
      .vtx_req      (vtx_req),
      .ctx_req      (ctx_req),
      .vtx_rdata_ff (vtx_rdata),
      .ctx_rdata_ff (ctx_rdata)
   );

   esu_acc u_acc (
      .clock    (clock),
      .reset    (reset),
      .req      (acc_req),
      .rdata    (acc_rdata)
   );

   esu_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   // Handshake and common derived values.
   logic                               accept;
   logic [DIM_W-1:0]                   elem_idx;
   logic                               elem_last;
   logic signed [esu_pkg::ELEM_W-1:0]  t_sel;
   logic [VTX_W-1:0]                   req_src;
   logic [DIM_W-1:0]                   req_elem;
   logic [LEN_W-1:0]                   len_eff;
   logic signed [esu_pkg::DOT_W-1:0]   dot_shift;
   logic [esu_pkg::QUOT_W+esu_pkg::RECIP_W-1:0] quot_prod;
   logic signed [esu_pkg::MUL_A_W-1:0] diff;
   logic signed [esu_pkg::ELEM_W-1:0]  tgt_new;
   logic signed [esu_pkg::ELEM_W-1:0]  src_new;
   logic signed [esu_pkg::ACC_W-1:0]   acc_new;
   logic signed [esu_pkg::GRAD_W-1:0]  g_new;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign elem_idx  = elem_ff[DIM_W-1:0];
   assign elem_last = ((elem_ff + LEN_W'(1)) == len_ff);
   assign t_sel     = order_mode_ff ? ctx_rdata : vtx_rdata;
   assign req_src   = req_source_vertex[VTX_W-1:0];
   assign req_elem  = req_element_index[DIM_W-1:0];
   assign len_eff   = (LEN_W'(vector_length_ff) > LEN_W'(esu_pkg::MAX_DIM)) ?
                      LEN_W'(esu_pkg::MAX_DIM) : LEN_W'(vector_length_ff);

   // Sigmoid index: floor(x * ENTRIES / 2^26) then divide by three by reciprocal.
   assign dot_shift = dot_ff + esu_pkg::SIG_BOUND_DOT;
   assign quot_prod = (esu_pkg::QUOT_W+esu_pkg::RECIP_W)'(
                         scaled_ff[esu_pkg::SCALED_W-1:esu_pkg::SPAN_SHIFT]) *
                      (esu_pkg::QUOT_W+esu_pkg::RECIP_W)'(esu_pkg::RECIP3);
   assign diff      = (label_ff ? esu_pkg::MUL_A_W'(esu_pkg::ONE_Q16) : '0) -
                      signed'({1'b0, sig_ff});

   // Rounding and saturation of the update results.
   assign g_new   = esu_pkg::GRAD_W'(esu_pkg::round_shift(48'(product), 16));
   assign acc_new = esu_pkg::ACC_W'(esu_pkg::sat_bits(
                       48'(acc_rdata) + esu_pkg::round_shift(48'(product), 12), 24));
   assign tgt_new = esu_pkg::ELEM_W'(esu_pkg::sat_bits(
                       48'(t_ff) + esu_pkg::round_shift(48'(product), 16), 16));
   assign src_new = esu_pkg::ELEM_W'(esu_pkg::sat_bits(
                       48'(vtx_rdata) + esu_pkg::round_shift(48'(acc_rdata), 4), 16));

   // Store addressing and multiplier operand selection.
   always_comb begin
      vtx_req           = '0;
      ctx_req           = '0;
      acc_req           = '0;
      acc_req.raddr     = elem_idx;
      acc_req.waddr     = elem_idx;
      acc_req.wdata     = acc_new;
      mul_a             = '0;
      mul_b             = '0;
      case (state_ff)
         S_IDLE: begin
            vtx_req.raddr = {req_src, req_elem};
            ctx_req.raddr = {req_src, req_elem};
            vtx_req.waddr = {req_src, req_elem};
            ctx_req.waddr = {req_src, req_elem};
            vtx_req.wdata = req_element_value;
            ctx_req.wdata = req_element_value;
            vtx_req.we    = accept && (req_operation == esu_pkg::OP_WR_VTX);
            ctx_req.we    = accept && (req_operation == esu_pkg::OP_WR_CTX);
         end
         S_DOT, S_UPD: begin
            if (phase_ff == 3'd0) begin
               vtx_req.raddr = {src_ff, elem_idx};
            end else begin
               vtx_req.raddr = {tgt_ff, elem_idx};
            end
            ctx_req.raddr = {tgt_ff, elem_idx};
            vtx_req.waddr = {tgt_ff, elem_idx};
            ctx_req.waddr = {tgt_ff, elem_idx};
            vtx_req.wdata = tgt_new;
            ctx_req.wdata = tgt_new;
            if (phase_ff == 3'd2) begin
               mul_a = (state_ff == S_DOT) ? esu_pkg::MUL_A_W'(s_ff) :
                                             esu_pkg::MUL_A_W'(g_ff);
               mul_b = esu_pkg::MUL_B_W'(t_sel);
            end else if (phase_ff == 3'd3) begin
               mul_a = esu_pkg::MUL_A_W'(g_ff);
               mul_b = esu_pkg::MUL_B_W'(s_ff);
            end
            if (state_ff == S_UPD) begin
               acc_req.we = (phase_ff == 3'd3);
               vtx_req.we = (phase_ff == 3'd4) && !order_mode_ff;
               ctx_req.we = (phase_ff == 3'd4) && order_mode_ff;
            end
         end
         S_GRAD_MUL: begin
            mul_a = diff;
            mul_b = signed'({1'b0, learning_rate_ff});
         end
         S_LAST: begin
            vtx_req.raddr = {src_ff, elem_idx};
            vtx_req.waddr = {src_ff, elem_idx};
            vtx_req.wdata = src_new;
            vtx_req.we    = (phase_ff == 3'd1) && (len_ff != '0);
            acc_req.clear_all = (phase_ff == 3'd1) && (elem_last || len_ff == '0);
         end
         default: begin
         end
      endcase
   end

   // Sequencer: state, per-element phases and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         elem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  src_ff           <= req_src;
                  tgt_ff           <= req_target_vertex[VTX_W-1:0];
                  label_ff         <= req_label;
                  last_ff          <= req_last_of_sample;
                  len_ff           <= len_eff;
                  elem_ff          <= '0;
                  phase_ff         <= '0;
                  dot_ff           <= '0;
                  rsp_read_data_ff <= '0;
                  rsp_grad_ff      <= '0;
                  if (req_operation == esu_pkg::OP_TRAIN) begin
                     state_ff <= (len_eff == '0) ? S_SIG_RANGE : S_DOT;
                  end else if (req_operation == esu_pkg::OP_RD_VTX ||
                               req_operation == esu_pkg::OP_RD_CTX) begin
                     state_ff <= S_READ;
                     last_ff  <= (req_operation == esu_pkg::OP_RD_CTX);
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               rsp_read_data_ff <= last_ff ? ctx_rdata : vtx_rdata;
               rsp_valid_ff     <= 1'b1;
               state_ff         <= S_IDLE;
            end
            S_DOT: begin
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd1) begin
                  s_ff <= vtx_rdata;
               end else if (phase_ff == 3'd3) begin
                  dot_ff   <= dot_ff + esu_pkg::DOT_W'(product);
                  phase_ff <= '0;
                  elem_ff  <= elem_ff + LEN_W'(1);
                  if (elem_last) begin
                     state_ff <= S_SIG_RANGE;
                  end
               end
            end
            S_SIG_RANGE: begin
               if (dot_ff > esu_pkg::SIG_BOUND_DOT) begin
                  sig_ff   <= esu_pkg::SIG_W'(esu_pkg::ONE_Q16);
                  state_ff <= S_GRAD_MUL;
               end else if (dot_ff < -esu_pkg::SIG_BOUND_DOT) begin
                  sig_ff   <= '0;
                  state_ff <= S_GRAD_MUL;
               end else begin
                  scaled_ff <= esu_pkg::SCALED_W'(dot_shift[esu_pkg::SPAN_W-1:0]) *
                               esu_pkg::SCALED_W'(esu_pkg::SIGMOID_ENTRIES);
                  state_ff  <= S_SIG_DIV;
               end
            end
            S_SIG_DIV: begin
               kq_ff    <= esu_pkg::KQ_W'(quot_prod >> esu_pkg::RECIP_SHIFT);
               state_ff <= S_SIG_ROM;
            end
            S_SIG_ROM: begin
               if (kq_ff >= esu_pkg::KQ_W'(esu_pkg::SIGMOID_ENTRIES)) begin
                  sig_ff <= esu_pkg::SIG_W'(esu_pkg::ONE_Q16);
               end else begin
                  sig_ff <= esu_pkg::SIG_W'(
                               esu_pkg::SIG_ROM[kq_ff[esu_pkg::SIG_IDX_W-1:0]]);
               end
               state_ff <= S_GRAD_MUL;
            end
            S_GRAD_MUL: begin
               state_ff <= S_GRAD_RND;
            end
            S_GRAD_RND: begin
               g_ff     <= g_new;
               elem_ff  <= '0;
               phase_ff <= '0;
               if (len_ff != '0) begin
                  state_ff <= S_UPD;
               end else if (last_ff) begin
                  state_ff <= S_LAST;
                  phase_ff <= 3'd1;
               end else begin
                  rsp_grad_ff  <= g_new;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_UPD: begin
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd1) begin
                  s_ff <= vtx_rdata;
               end else if (phase_ff == 3'd2) begin
                  t_ff <= t_sel;
               end else if (phase_ff == 3'd4) begin
                  phase_ff <= '0;
                  elem_ff  <= elem_ff + LEN_W'(1);
                  if (elem_last) begin
                     elem_ff <= '0;
                     if (last_ff) begin
                        state_ff <= S_LAST;
                     end else begin
                        rsp_grad_ff  <= g_ff;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end
               end
            end
            S_LAST: begin
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd1) begin
                  phase_ff <= '0;
                  elem_ff  <= elem_ff + LEN_W'(1);
                  if (elem_last || len_ff == '0) begin
                     rsp_grad_ff  <= g_ff;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_gradient_scale = rsp_grad_ff;

endmodule

`default_nettype wire
